// ===== rtl/rdd_pkg.sv =====
// Shared types and codes for the resource deadlock detector.
`default_nettype none

package rdd_pkg;

   localparam logic [1:0] KIND_AVAIL = 2'd0;
   localparam logic [1:0] KIND_HELD  = 2'd1;
   localparam logic [1:0] KIND_WANT  = 2'd2;
   localparam logic [1:0] KIND_RUN   = 2'd3;

   localparam logic [0:0] CSR_PROCESS_COUNT  = 1'b0;
   localparam logic [0:0] CSR_RESOURCE_COUNT = 1'b1;

   localparam int CSR_DATA_WIDTH = 4;
   localparam logic [CSR_DATA_WIDTH-1:0] COUNT_REG_RESET = 4'd8;

   localparam int MASK_WIDTH = 8;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  proc_index;
      logic [2:0]  res_index;
      logic [15:0] count_value;
   } req_item_type;

   typedef struct packed {
      logic                  deadlocked;
      logic [MASK_WIDTH-1:0] blocked_mask;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/rdd_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module rdd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/rdd_engine.sv =====
// Sweep sequencer: work vector RAM, fit check, saturating release and result register.
`default_nettype none

module rdd_engine import rdd_pkg::*; #(
   parameter int MAX_PROCS     = 8,
   parameter int MAX_RESOURCES = 8,
   parameter int COUNT_WIDTH   = 16,
   parameter int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1,
   parameter int TW  = $clog2(MAX_PROCS * MAX_RESOURCES),
   parameter int NPW = $clog2(MAX_PROCS + 1),
   parameter int NRW = $clog2(MAX_RESOURCES + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [NPW-1:0]         np,
   input  wire logic [NRW-1:0]         nr,
   input  wire logic [COUNT_WIDTH-1:0] avail_q,
   input  wire logic [COUNT_WIDTH-1:0] want_q,
   input  wire logic [COUNT_WIDTH-1:0] held_q,
   output logic      [RW-1:0]          rd_res_addr,
   output logic      [TW-1:0]          rd_tbl_addr,
   output logic                        busy,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_item_type                rsp_item
);

   localparam int PW = $clog2(MAX_PROCS);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_COPY   = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_CHECK  = 7'b0001000,
      ST_ADD    = 7'b0010000,
      ST_NEXT   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [PW-1:0]          p_ff, p_in;
   logic [TW-1:0]          row_ff, row_in;
   logic [RW-1:0]          r_ff, r_in;
   logic [RW-1:0]          r1_ff;
   logic                   issue_ff, issue_in;
   logic                   v1_ff;
   logic                   fit_ff, fit_in;
   logic                   progress_ff, progress_in;
   logic [MAX_PROCS-1:0]   done_ff, done_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_item_type           rsp_item_ff, rsp_item_in;

   logic                   r_last;
   logic                   p_last;
   logic                   pass_end;
   logic [COUNT_WIDTH-1:0] work_q;
   logic                   work_we;
   logic [COUNT_WIDTH-1:0] work_wdata;
   logic [COUNT_WIDTH:0]   sum;
   logic [MAX_PROCS-1:0]   taking_part;
   logic [MAX_PROCS-1:0]   blocked;
   logic [MASK_WIDTH-1:0]  mask;

   assign r_last   = (NRW'(r_ff) + NRW'(1)) == nr;
   assign p_last   = (NPW'(p_ff) + NPW'(1)) == np;
   assign pass_end = !issue_ff && !v1_ff;

   assign rd_res_addr = r_ff;
   assign rd_tbl_addr = row_ff + TW'(r_ff);

   assign sum = {1'b0, work_q} + {1'b0, held_q};

   always_comb begin
      work_we    = v1_ff && (state_ff == ST_COPY || state_ff == ST_ADD);
      work_wdata = avail_q;
      if (state_ff == ST_ADD) begin
         work_wdata = sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
      end
   end

   rdd_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MAX_RESOURCES),
      .AW    (RW)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (work_we),
      .wr_addr (r1_ff),
      .wr_data (work_wdata),
      .rd_addr (r_ff),
      .rd_data (work_q)
   );

   always_comb begin
      for (int i = 0; i < MAX_PROCS; i++) begin
         taking_part[i] = i < 32'(np);
      end
   end

   assign blocked = taking_part & ~done_ff;

   for (genvar j = 0; j < MASK_WIDTH; j++) begin : g_mask
      if (j < MAX_PROCS) begin : g_bit
         assign mask[j] = blocked[j];
      end else begin : g_zero
         assign mask[j] = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      row_in       = row_ff;
      r_in         = r_ff;
      issue_in     = issue_ff;
      fit_in       = fit_ff;
      progress_in  = progress_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;

      if (issue_ff) begin
         if (r_last) begin
            issue_in = 1'b0;
         end else begin
            r_in = r_ff + RW'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               done_in     = '0;
               progress_in = 1'b0;
               p_in        = '0;
               row_in      = '0;
               r_in        = '0;
               if (np == '0) begin
                  state_in = ST_FINISH;
               end else if (nr == '0) begin
                  state_in = ST_SCAN;
               end else begin
                  issue_in = 1'b1;
                  state_in = ST_COPY;
               end
            end
         end
         ST_COPY: begin
            if (pass_end) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (done_ff[p_ff]) begin
               state_in = ST_NEXT;
            end else if (nr == '0) begin
               done_in[p_ff] = 1'b1;
               progress_in   = 1'b1;
               state_in      = ST_NEXT;
            end else begin
               r_in     = '0;
               issue_in = 1'b1;
               fit_in   = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (v1_ff && want_q > work_q) begin
               fit_in = 1'b0;
            end
            if (pass_end) begin
               if (fit_ff) begin
                  r_in     = '0;
                  issue_in = 1'b1;
                  state_in = ST_ADD;
               end else begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_ADD: begin
            if (pass_end) begin
               done_in[p_ff] = 1'b1;
               progress_in   = 1'b1;
               state_in      = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (p_last) begin
               if (progress_ff) begin
                  p_in        = '0;
                  row_in      = '0;
                  progress_in = 1'b0;
                  state_in    = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               p_in     = p_ff + PW'(1);
               row_in   = row_ff + TW'(MAX_RESOURCES);
               state_in = ST_SCAN;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.deadlocked   = |blocked;
               rsp_item_in.blocked_mask = mask;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         v1_ff        <= issue_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff        <= p_in;
      row_ff      <= row_in;
      r_ff        <= r_in;
      r1_ff       <= r_ff;
      fit_ff      <= fit_in;
      progress_ff <= progress_in;
      done_ff     <= done_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

// ===== rtl/resource_deadlock_detector_unit.sv =====
// Top level: count registers, load path into the count stores, sweep engine.
// Load items are accepted back to back while no check runs.
// A run item sweeps the processes at most np + 1 times (np the clamped process count),
// reading the work and table RAMs once per resource per pass.
// The result waits in an output register; loads are taken while it waits.
// Synchronous reset clears control state and sets both counts to 8; store contents
// stay undefined until written.
`default_nettype none

module resource_deadlock_detector_unit import rdd_pkg::*; #(
   parameter int MAX_PROCS     = 8,
   parameter int MAX_RESOURCES = 8,
   parameter int COUNT_WIDTH   = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire req_item_type              req_item,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output rsp_item_type                   rsp_item,
   input  wire logic                      csr_we,
   input  wire logic [0:0]                csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int TW  = $clog2(MAX_PROCS * MAX_RESOURCES);
   localparam int NPW = $clog2(MAX_PROCS + 1);
   localparam int NRW = $clog2(MAX_RESOURCES + 1);

   logic [CSR_DATA_WIDTH-1:0] proc_count_ff, proc_count_in;
   logic [CSR_DATA_WIDTH-1:0] res_count_ff, res_count_in;

   logic [NPW-1:0]         np;
   logic [NRW-1:0]         nr;
   logic                   busy;
   logic                   accept;
   logic                   start;
   logic                   res_ok;
   logic                   proc_ok;
   logic                   avail_we;
   logic                   held_we;
   logic                   want_we;
   logic [RW-1:0]          load_res_addr;
   logic [TW-1:0]          load_tbl_addr;
   logic [COUNT_WIDTH-1:0] load_value;
   logic [RW-1:0]          eng_res_addr;
   logic [TW-1:0]          eng_tbl_addr;
   logic [COUNT_WIDTH-1:0] avail_q;
   logic [COUNT_WIDTH-1:0] held_q;
   logic [COUNT_WIDTH-1:0] want_q;

   always_comb begin
      proc_count_in = proc_count_ff;
      res_count_in  = res_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PROCESS_COUNT:  proc_count_in = csr_wdata;
            CSR_RESOURCE_COUNT: res_count_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_count_ff <= COUNT_REG_RESET;
         res_count_ff  <= COUNT_REG_RESET;
      end else begin
         proc_count_ff <= proc_count_in;
         res_count_ff  <= res_count_in;
      end
   end

   assign np = (32'(proc_count_ff) > MAX_PROCS) ? NPW'(MAX_PROCS) : NPW'(proc_count_ff);
   assign nr = (32'(res_count_ff) > MAX_RESOURCES) ? NRW'(MAX_RESOURCES)
                                                     : NRW'(res_count_ff);

   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;
   assign start     = accept && req_item.kind == KIND_RUN;

   assign res_ok   = 32'(req_item.res_index) < MAX_RESOURCES;
   assign proc_ok  = 32'(req_item.proc_index) < MAX_PROCS;
   assign avail_we = accept && res_ok && req_item.kind == KIND_AVAIL;
   assign held_we  = accept && res_ok && proc_ok && req_item.kind == KIND_HELD;
   assign want_we  = accept && res_ok && proc_ok && req_item.kind == KIND_WANT;

   assign load_res_addr = RW'(req_item.res_index);
   assign load_tbl_addr = TW'(32'(req_item.proc_index) * 32'(MAX_RESOURCES)
                              + 32'(req_item.res_index));
   assign load_value    = COUNT_WIDTH'(req_item.count_value);

   rdd_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MAX_RESOURCES),
      .AW    (RW)
   ) u_avail_ram (
      .clock   (clock),
      .wr_en   (avail_we),
      .wr_addr (load_res_addr),
      .wr_data (load_value),
      .rd_addr (eng_res_addr),
      .rd_data (avail_q)
   );

   rdd_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MAX_PROCS * MAX_RESOURCES),
      .AW    (TW)
   ) u_held_ram (
      .clock   (clock),
      .wr_en   (held_we),
      .wr_addr (load_tbl_addr),
      .wr_data (load_value),
      .rd_addr (eng_tbl_addr),
      .rd_data (held_q)
   );

   rdd_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MAX_PROCS * MAX_RESOURCES),
      .AW    (TW)
   ) u_want_ram (
      .clock   (clock),
      .wr_en   (want_we),
      .wr_addr (load_tbl_addr),
      .wr_data (load_value),
      .rd_addr (eng_tbl_addr),
      .rd_data (want_q)
   );

   rdd_engine #(
      .MAX_PROCS     (MAX_PROCS),
      .MAX_RESOURCES (MAX_RESOURCES),
      .COUNT_WIDTH   (COUNT_WIDTH),
      .RW            (RW),
      .TW            (TW),
      .NPW           (NPW),
      .NRW           (NRW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .np          (np),
      .nr          (nr),
      .avail_q     (avail_q),
      .want_q      (want_q),
      .held_q      (held_q),
      .rd_res_addr (eng_res_addr),
      .rd_tbl_addr (eng_tbl_addr),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the resource deadlock detector unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rdd_pkg::*;

   localparam int PROCS     = 8;
   localparam int RESOURCES = 8;
   localparam int COUNT_TOP = 65535;
   localparam logic [1:0] LOAD_KINDS [3] = '{KIND_AVAIL, KIND_HELD, KIND_WANT};

   typedef enum int {COUNTS_SMALL, COUNTS_FULL, COUNTS_EDGE} count_style_type;
   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_HELD_OFF} ready_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   logic csr_we = 1'b0;
   logic [0:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // predictor state
   logic [3:0]  proc_limit = COUNT_REG_RESET;
   logic [3:0]  res_limit  = COUNT_REG_RESET;
   logic [15:0] avail_cnt [RESOURCES];
   logic [15:0] held_cnt [PROCS][RESOURCES];
   logic [15:0] want_cnt [PROCS][RESOURCES];

   req_item_type req_backlog [$];
   rsp_item_type verdict_q [$];
   rsp_item_type due_verdict;
   int error_count = 0;
   int queued_count = 0;
   int runs_queued = 0;
   int burst_left = 4;
   int gap_left = 0;
   int ready_left = 0;
   ready_style_type ready_mode = READY_ALWAYS;

   resource_deadlock_detector_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item(rsp_item),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(20_000_000);
      $display("status: fail");
      $finish;
   end

   task automatic flag_mismatch(string what);
      error_count++;
      if (error_count <= 100) $display("mismatch at %0t: %s", $time, what);
   endtask

   function automatic rsp_item_type compute_verdict();
      int unsigned np, nr, sum;
      int unsigned work [RESOURCES];
      bit finished [PROCS];
      bit moved, fits;
      rsp_item_type verdict;
      np = (proc_limit > PROCS) ? PROCS : proc_limit;
      nr = (res_limit > RESOURCES) ? RESOURCES : res_limit;
      for (int r = 0; r < RESOURCES; r++) work[r] = avail_cnt[r];
      for (int p = 0; p < PROCS; p++) finished[p] = 1'b0;
      do begin
         moved = 1'b0;
         for (int p = 0; p < np; p++) begin
            if (!finished[p]) begin
               fits = 1'b1;
               for (int r = 0; r < nr; r++)
                  if (want_cnt[p][r] > work[r]) fits = 1'b0;
               if (fits) begin
                  for (int r = 0; r < nr; r++) begin
                     sum = work[r] + held_cnt[p][r];
                     work[r] = (sum > COUNT_TOP) ? COUNT_TOP : sum;
                  end
                  finished[p] = 1'b1;
                  moved = 1'b1;
               end
            end
         end
      end while (moved);
      verdict = '0;
      for (int p = 0; p < np; p++) begin
         if (!finished[p]) begin
            verdict.deadlocked = 1'b1;
            verdict.blocked_mask[p] = 1'b1;
         end
      end
      return verdict;
   endfunction

   task automatic apply_item(req_item_type it);
      case (it.kind)
         KIND_AVAIL: avail_cnt[it.res_index] = it.count_value;
         KIND_HELD:  held_cnt[it.proc_index][it.res_index] = it.count_value;
         KIND_WANT:  want_cnt[it.proc_index][it.res_index] = it.count_value;
         default:    verdict_q.push_back(compute_verdict());
      endcase
   endtask

   // sender: bursts of items separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) apply_item(req_item);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_valid <= 1'b1;
               req_item <= req_backlog.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each verdict, stall on a pattern of its own
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            flag_mismatch("verdict with no run pending");
         end else begin
            due_verdict = verdict_q.pop_front();
            if (rsp_item.deadlocked !== due_verdict.deadlocked)
               flag_mismatch($sformatf("deadlocked %b, expected %b",
                  rsp_item.deadlocked, due_verdict.deadlocked));
            if (rsp_item.blocked_mask !== due_verdict.blocked_mask)
               flag_mismatch($sformatf("blocked_mask %b, expected %b",
                  rsp_item.blocked_mask, due_verdict.blocked_mask));
         end
      end
      if (ready_left == 0) begin
         ready_mode = ready_style_type'($urandom_range(0, 3));
         ready_left = $urandom_range(1, 64);
      end
      ready_left--;
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN:   rsp_ready <= ($urandom_range(0, 1) == 0);
         READY_SPARSE: rsp_ready <= ($urandom_range(0, 5) == 0);
         default:      rsp_ready <= 1'b0;
      endcase
   end

   function automatic logic [15:0] rand_count(count_style_type style);
      case (style)
         COUNTS_SMALL: return 16'($urandom_range(0, 7));
         COUNTS_FULL:  return 16'($urandom_range(0, COUNT_TOP));
         default: begin
            case ($urandom_range(0, 3))
               0: return 16'd0;
               1: return 16'd1;
               2: return 16'hFFFE;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [3:0] pick_limit();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 4'd0;
      if (roll == 1) return 4'($urandom_range(9, 15));
      if (roll < 5) return 4'd8;
      return 4'($urandom_range(1, 4));
   endfunction

   task automatic queue_item(logic [1:0] kind, int p, int r, logic [15:0] value);
      req_item_type it;
      it.kind = kind;
      it.proc_index = p[2:0];
      it.res_index = r[2:0];
      it.count_value = value;
      req_backlog.push_back(it);
      queued_count++;
   endtask

   task automatic queue_check();
      queue_item(KIND_RUN, $urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom));
      runs_queued++;
   endtask

   // wait until the block is idle with nothing outstanding
   task automatic settle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || verdict_q.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(logic [0:0] idx, logic [3:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_PROCESS_COUNT) proc_limit = value;
      else res_limit = value;
   endtask

   // rewrite the active region so that processes finish in a shuffled order,
   // some of them made to ask for more than the pool can give
   task automatic queue_chain();
      int np, nr, block_rate, j, tmp;
      int order [PROCS];
      int unsigned work [RESOURCES];
      count_style_type held_style, avail_style;
      logic [15:0] value;
      np = (proc_limit > PROCS) ? PROCS : int'(proc_limit);
      nr = (res_limit > RESOURCES) ? RESOURCES : int'(res_limit);
      block_rate = $urandom_range(0, 2);
      held_style = count_style_type'($urandom_range(0, 2));
      avail_style = count_style_type'($urandom_range(0, 2));
      for (int r = 0; r < nr; r++) begin
         value = rand_count(avail_style);
         work[r] = value;
         queue_item(KIND_AVAIL, $urandom_range(0, 7), r, value);
      end
      for (int i = 0; i < PROCS; i++) order[i] = i;
      for (int i = np - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < np; i++) begin
         if ($urandom_range(0, 3) < block_rate) begin
            j = (nr > 0) ? $urandom_range(0, nr - 1) : 0;
            for (int r = 0; r < nr; r++) begin
               value = (r == j) ? 16'hFFFF : rand_count(COUNTS_SMALL);
               queue_item(KIND_WANT, order[i], r, value);
               queue_item(KIND_HELD, order[i], r, rand_count(held_style));
            end
         end else begin
            for (int r = 0; r < nr; r++) begin
               queue_item(KIND_WANT, order[i], r, 16'($urandom_range(0, work[r])));
               value = rand_count(held_style);
               queue_item(KIND_HELD, order[i], r, value);
               work[r] = (work[r] + value > COUNT_TOP) ? COUNT_TOP : work[r] + value;
            end
         end
      end
      queue_check();
   endtask

   task automatic queue_touch(bit with_check);
      int n;
      n = $urandom_range(1, 6);
      repeat (n)
         queue_item(LOAD_KINDS[$urandom_range(0, 2)], $urandom_range(0, 7),
            $urandom_range(0, 7), rand_count(count_style_type'($urandom_range(0, 2))));
      if (with_check) queue_check();
   endtask

   initial begin
      int pick;
      wait (!reset);
      // every store entry gets written before the first check
      for (int r = 0; r < RESOURCES; r++)
         queue_item(KIND_AVAIL, $urandom_range(0, 7), r, rand_count(COUNTS_SMALL));
      for (int p = 0; p < PROCS; p++) begin
         for (int r = 0; r < RESOURCES; r++) begin
            queue_item(KIND_HELD, p, r, rand_count(COUNTS_SMALL));
            queue_item(KIND_WANT, p, r, rand_count(COUNTS_SMALL));
         end
      end
      queue_check();
      settle();

      // work sum saturates, letting a full-scale request fit
      write_limit(CSR_PROCESS_COUNT, 4'd2);
      write_limit(CSR_RESOURCE_COUNT, 4'd1);
      queue_item(KIND_AVAIL, 7, 0, 16'd1);
      queue_item(KIND_HELD, 0, 0, 16'hFFFF);
      queue_item(KIND_WANT, 0, 0, 16'd0);
      queue_item(KIND_HELD, 1, 0, 16'hFFFF);
      queue_item(KIND_WANT, 1, 0, 16'hFFFF);
      queue_check();
      settle();

      // last process starved on the last resource
      write_limit(CSR_PROCESS_COUNT, 4'd8);
      write_limit(CSR_RESOURCE_COUNT, 4'd8);
      queue_item(KIND_AVAIL, 0, 7, 16'd0);
      queue_item(KIND_WANT, 7, 7, 16'hFFFF);
      queue_item(KIND_HELD, 7, 7, 16'd0);
      queue_check();
      settle();

      // no process taking part
      write_limit(CSR_PROCESS_COUNT, 4'd0);
      queue_check();
      settle();

      // no resource: every request fits; process count above the maximum
      write_limit(CSR_PROCESS_COUNT, 4'd15);
      write_limit(CSR_RESOURCE_COUNT, 4'd0);
      queue_check();
      settle();

      write_limit(CSR_RESOURCE_COUNT, 4'd15);
      queue_check();
      settle();

      // single process that cannot start
      write_limit(CSR_PROCESS_COUNT, 4'd1);
      write_limit(CSR_RESOURCE_COUNT, 4'd8);
      queue_item(KIND_AVAIL, 3, 0, 16'd0);
      queue_item(KIND_WANT, 0, 0, 16'd1);
      queue_check();
      settle();

      queued_count = 0;
      runs_queued = 0;
      while (queued_count < 1000 || runs_queued < 60) begin
         write_limit(CSR_PROCESS_COUNT, pick_limit());
         write_limit(CSR_RESOURCE_COUNT, pick_limit());
         repeat ($urandom_range(1, 4)) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) queue_chain();
            else if (pick < 9) queue_touch(1'b1);
            else queue_touch(1'b0);
         end
         settle();
      end

      repeat (2000) @(posedge clock);
      if (verdict_q.size() != 0)
         flag_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rdd_pkg.sv
rtl/rdd_ram.sv
rtl/rdd_engine.sv
rtl/resource_deadlock_detector_unit.sv
tb/tb.sv
